// ----- rtl/gha_pkg.sv -----
// gha_pkg: shared types and constants of the generational handle allocator
// request/status codes and default sizes; no dependencies
package gha_pkg;

  localparam int MAX_HANDLES_DEF  = 1024;
  localparam int VERSION_BITS_DEF = 16;
  localparam int IDX_BITS_DEF     = $clog2(MAX_HANDLES_DEF);

  typedef enum logic {
    MODE_CREATE  = 1'b0,
    MODE_DESTROY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEAD  = 2'd2,
    ST_NEVER = 2'd3
  } status_t;

endpackage

// ----- rtl/gha_if.sv -----
// gha_if: request and response channels of the generational handle allocator
// valid/ready handshake with payload; depends on gha_pkg
interface gha_req_if import gha_pkg::*; #(
  parameter int IDX_BITS = IDX_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_BITS-1:0] target_index;

  modport source (output valid, output mode, output target_index, input ready);
  modport sink   (input valid, input mode, input target_index, output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; #(
  parameter int IDX_BITS = IDX_BITS_DEF,
  parameter int VER_BITS = VERSION_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] handle_index;
  logic [VER_BITS-1:0] handle_version;
  logic [1:0]          status;

  modport source (output valid, output handle_index, output handle_version, output status,
                  input ready);
  modport sink   (input valid, input handle_index, input handle_version, input status,
                  output ready);
endinterface

// ----- rtl/generational_handle_allocator.sv -----
// generational_handle_allocator: handle allocator with free stack and version table
// depends on gha_pkg and the gha_req_if / gha_rsp_if channels
//
// usage
//   req channel: one beat per request, mode selects create or destroy,
//     target_index names the entry to destroy (ignored on create)
//   rsp channel: exactly one beat per request, in request order, carrying
//     the index, its version after the operation and a status code
//   path: each request passes the request register, then the result register
//   throughput: one request per cycle while rsp.ready holds; set by the single
//     read-modify-write pass over the version and destroyed-mark memories,
//     with the last commit forwarded into the following request
//   reset: rst (synchronous) clears both counters and the pipeline valid
//     bits; the memories are not cleared, an entry is initialised when its
//     index is first handed out
//   stall: while the result register is full and not taken, the request
//     register holds one more request; once both are full req.ready drops
//   freed entries keep their version on the free stack, so a create that
//   reuses an index reads only the stack
module generational_handle_allocator import gha_pkg::*; #(
  parameter int MAX_HANDLES  = MAX_HANDLES_DEF,
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gha_req_if.sink   req,
  gha_rsp_if.source rsp
);

  localparam int IW = $clog2(MAX_HANDLES);     // index width
  localparam int CW = IW + 1;                  // counter width, holds MAX_HANDLES
  localparam int SW = IW + VERSION_BITS;       // free stack entry: index and version
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_HANDLES);

  // storage
  logic [SW-1:0]           stack_mem [MAX_HANDLES];
  logic [VERSION_BITS-1:0] ver_mem   [MAX_HANDLES];
  logic                    dead_mem  [MAX_HANDLES];

  // counters
  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] fresh_count, fresh_count_next;

  // request register and its registered memory reads
  logic                    s1_valid;
  mode_t                   s1_mode;
  logic [IW-1:0]           s1_target;
  logic [SW-1:0]           stack_rd;
  logic [VERSION_BITS-1:0] ver_rd;
  logic                    dead_rd;

  // writes committed in the same edge as the read, so missed by it
  logic                    fwd_stack_hit;
  logic [SW-1:0]           fwd_stack_data;
  logic                    fwd_ver_hit;
  logic [VERSION_BITS-1:0] fwd_ver_data;
  logic                    fwd_dead_hit;
  logic                    fwd_dead_data;

  // result register
  logic                    out_valid;
  logic [IW-1:0]           out_index;
  logic [VERSION_BITS-1:0] out_version;
  status_t                 out_status;

  // handshake
  logic out_free, commit, in_ready, accept;

  // commit pass
  logic [SW-1:0]           stack_entry;
  logic [VERSION_BITS-1:0] cur_ver, ver_inc;
  logic                    cur_dead;
  logic [IW-1:0]           res_index;
  logic [VERSION_BITS-1:0] res_version;
  status_t                 res_status;
  logic                    stk_we, ver_we, dead_we;
  logic [IW-1:0]           stk_wa, ver_wa, dead_wa, stk_ra;
  logic [SW-1:0]           stk_wd;
  logic [VERSION_BITS-1:0] ver_wd;
  logic                    dead_wd;

  assign out_free = !out_valid || rsp.ready;
  assign commit   = s1_valid && out_free;
  assign in_ready = !s1_valid || commit;
  assign accept   = req.valid && in_ready;

  assign req.ready          = in_ready;
  assign rsp.valid          = out_valid;
  assign rsp.handle_index   = out_index;
  assign rsp.handle_version = out_version;
  assign rsp.status         = out_status;

  // one pass over the request in s1: decide the result and the writes
  always_comb begin
    stack_entry      = fwd_stack_hit ? fwd_stack_data : stack_rd;
    cur_ver          = fwd_ver_hit ? fwd_ver_data : ver_rd;
    cur_dead         = fwd_dead_hit ? fwd_dead_data : dead_rd;
    ver_inc          = cur_ver + VERSION_BITS'(1);
    res_index        = '0;
    res_version      = '0;
    res_status       = ST_OK;
    stk_we           = 1'b0;
    stk_wa           = free_count[IW-1:0];
    stk_wd           = {s1_target, ver_inc};
    ver_we           = 1'b0;
    ver_wa           = s1_target;
    ver_wd           = ver_inc;
    dead_we          = 1'b0;
    dead_wa          = s1_target;
    dead_wd          = 1'b1;
    free_count_next  = free_count;
    fresh_count_next = fresh_count;
    if (commit) begin
      if (s1_mode == MODE_CREATE) begin
        if (free_count != '0) begin
          // reuse the most recently freed index, version kept on the stack
          res_index       = stack_entry[SW-1 -: IW];
          res_version     = stack_entry[VERSION_BITS-1:0];
          dead_we         = 1'b1;
          dead_wa         = res_index;
          dead_wd         = 1'b0;
          free_count_next = free_count - CW'(1);
        end else if (fresh_count == MAX_COUNT) begin
          res_status = ST_FULL;
        end else begin
          // first use of a fresh index: initialise its entry
          res_index        = fresh_count[IW-1:0];
          ver_we           = 1'b1;
          ver_wa           = res_index;
          ver_wd           = '0;
          dead_we          = 1'b1;
          dead_wa          = res_index;
          dead_wd          = 1'b0;
          fresh_count_next = fresh_count + CW'(1);
        end
      end else begin
        res_index = s1_target;
        if ({1'b0, s1_target} >= fresh_count) begin
          res_status = ST_NEVER;
        end else if (cur_dead) begin
          res_status  = ST_DEAD;
          res_version = cur_ver;
        end else begin
          res_version = ver_inc;
          ver_we      = 1'b1;
          dead_we     = 1'b1;
          if (free_count != MAX_COUNT) begin
            stk_we          = 1'b1;
            free_count_next = free_count + CW'(1);
          end
        end
      end
    end
  end

  // pop address as seen after this edge's commit
  assign stk_ra = IW'(free_count_next - CW'(1));

  // memories, registered reads taken when a request enters
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (accept) begin
      stack_rd <= stack_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ver_we) begin
      ver_mem[ver_wa] <= ver_wd;
    end
    if (accept) begin
      ver_rd <= ver_mem[req.target_index];
    end
  end

  always_ff @(posedge clk) begin
    if (dead_we) begin
      dead_mem[dead_wa] <= dead_wd;
    end
    if (accept) begin
      dead_rd <= dead_mem[req.target_index];
    end
  end

  // request register payload and forwarding of the concurrent commit
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode        <= mode_t'(req.mode);
      s1_target      <= req.target_index;
      fwd_stack_hit  <= stk_we && (stk_wa == stk_ra);
      fwd_stack_data <= stk_wd;
      fwd_ver_hit    <= ver_we && (ver_wa == req.target_index);
      fwd_ver_data   <= ver_wd;
      fwd_dead_hit   <= dead_we && (dead_wa == req.target_index);
      fwd_dead_data  <= dead_wd;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_index   <= res_index;
      out_version <= res_version;
      out_status  <= res_status;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      free_count  <= '0;
      fresh_count <= '0;
    end else begin
      free_count  <= free_count_next;
      fresh_count <= fresh_count_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // only indices handed out can be on the free stack
  assert property (@(posedge clk) disable iff (rst) free_count <= fresh_count)
    else $error("free stack holds more entries than indices handed out");

  // a successful beat always names an index already handed out
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_OK) |-> ({1'b0, rsp.handle_index} < fresh_count))
    else $error("ok result names an index never handed out");

  // table full only once every fresh index has gone
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (fresh_count == MAX_COUNT))
    else $error("table full reported with fresh indices left");

endmodule
